// ----- sv/lupd_pkg.sv -----
package lupd_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;
    localparam int SIZE_W = 4;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PIV_ISSUE,
        ST_PIV_CHECK,
        ST_SWP_RD_A,
        ST_SWP_RD_B,
        ST_SWP_WR_A,
        ST_SWP_WR_B,
        ST_PERM_A,
        ST_PERM_B,
        ST_E_RD_P,
        ST_E_RD_A,
        ST_E_DIV_LD,
        ST_E_DIV,
        ST_E_DIV_WR,
        ST_E_RD_U,
        ST_E_RD_X,
        ST_E_MUL,
        ST_E_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_SING
    } state_t;

endpackage

// ----- sv/lup_decomposition.sv -----
// Loads n*n elements, one per cycle, then decomposes in place and streams n*n results
// (or a single result flagged singular when no nonzero pivot is found). Steps per column:
// pivot search over the rows, a row swap element by element when needed, a bit-serial
// divide for each multiplier, then an update of each trailing element, all through the
// matrix memory. Results leave one at a time and are held while m_ready is low.
// Synchronous active-low reset clears control state; the matrix memory is not cleared.
module lup_decomposition #(
    parameter int MAX_SIZE      = 8,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [1:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [lupd_pkg::DATA_W-1:0]   s_element,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lupd_pkg::DATA_W-1:0]   m_lu_value,
    output logic [lupd_pkg::IDX_W-1:0]           m_row,
    output logic [lupd_pkg::IDX_W-1:0]           m_column,
    output logic [lupd_pkg::IDX_W-1:0]           m_perm_column,
    output logic                                 m_singular,
    output logic                                 m_final_res
);

    localparam int DW     = lupd_pkg::DATA_W;
    localparam int IW     = lupd_pkg::IDX_W;
    localparam int SW     = lupd_pkg::SIZE_W;
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RO_W   = $clog2(MAX_SIZE);
    localparam int NUM_W  = DW + FRACTION_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int DIFF_W = 2 * DW + 2;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IW-1:0] r,
                                                  input logic [IW-1:0] c);
        addr_of = ADDR_W'(int'(r) * MAX_SIZE + int'(c));
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        mag = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    lupd_pkg::state_t state_reg, state_next;

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] mem_q_reg;
    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic                 wr_en;
    logic signed [DW-1:0] wr_data;

    logic [SW-1:0] size_reg;
    logic [IW-1:0] ld_row_reg, ld_col_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg, piv_reg;
    logic [DW-1:0] best_reg;
    logic signed [DW-1:0] tmp_reg, piv_val_reg, m_reg, u_reg, x_reg;
    logic [DW-1:0]     dvs_reg, rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              div_neg_reg;
    logic [2*DW-1:0]   prod_reg;
    logic              prod_neg_reg;
    logic [IW-1:0]     ro_reg [MAX_SIZE];
    logic [IW-1:0]     ro_tmp_reg;
    logic [RO_W-1:0]   ro_idx;

    logic              out_valid_reg;
    logic signed [DW-1:0] out_value_reg;
    logic [IW-1:0]     out_row_reg, out_col_reg, out_perm_reg;
    logic              out_sing_reg, out_final_reg;

    logic [SW-1:0] dim_n;
    logic [IW-1:0] n_last;
    logic          cfg_wr, in_acc, ld_last, out_free;
    logic [DW-1:0] q_mag;
    logic          piv_upd;
    logic [DW-1:0] best_new;
    logic [IW-1:0] piv_new;
    logic [DW:0]   trial;
    logic signed [DW-1:0] div_sat, diff_sat;
    logic signed [DIFF_W-1:0] diff;
    logic [2*DW-1:0] p_sh;

    always_comb begin
        if (size_reg == '0) begin
            dim_n = SW'(1);
        end else if (size_reg > SW'(MAX_SIZE)) begin
            dim_n = SW'(MAX_SIZE);
        end else begin
            dim_n = size_reg;
        end
        n_last   = IW'(dim_n - SW'(1));
        cfg_wr   = psel & penable & pwrite;
        in_acc   = s_valid & s_ready;
        ld_last  = (ld_row_reg == n_last) && (ld_col_reg == n_last);
        out_free = !out_valid_reg || m_ready;
        q_mag    = mag(mem_q_reg);
        piv_upd  = q_mag > best_reg;
        best_new = piv_upd ? q_mag : best_reg;
        piv_new  = piv_upd ? j_reg : piv_reg;
        trial    = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, dvs_reg};
        ro_idx   = (state_reg == lupd_pkg::ST_PERM_A) ? piv_reg[RO_W-1:0] : i_reg[RO_W-1:0];
    end

    always_comb begin
        if (div_neg_reg) begin
            div_sat = (quo_reg > NUM_W'(33'h0_8000_0000)) ? DW'(32'h8000_0000)
                                                          : DW'(-quo_reg[DW-1:0]);
        end else begin
            div_sat = (quo_reg > NUM_W'(33'h0_7FFF_FFFF)) ? DW'(32'h7FFF_FFFF)
                                                          : DW'(quo_reg[DW-1:0]);
        end
        p_sh = prod_reg >> FRACTION_BITS;
        if (prod_neg_reg) begin
            diff = DIFF_W'(x_reg) + $signed({2'b00, p_sh});
        end else begin
            diff = DIFF_W'(x_reg) - $signed({2'b00, p_sh});
        end
        if (diff > DIFF_W'(32'sh7FFF_FFFF)) begin
            diff_sat = DW'(32'h7FFF_FFFF);
        end else if (diff < -$signed(DIFF_W'(33'h0_8000_0000))) begin
            diff_sat = DW'(32'h8000_0000);
        end else begin
            diff_sat = diff[DW-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lupd_pkg::ST_LOAD: begin
                if (in_acc && ld_last && !cfg_wr) state_next = lupd_pkg::ST_PIV_ISSUE;
            end
            lupd_pkg::ST_PIV_ISSUE: state_next = lupd_pkg::ST_PIV_CHECK;
            lupd_pkg::ST_PIV_CHECK: begin
                if (j_reg != n_last) begin
                    state_next = lupd_pkg::ST_PIV_ISSUE;
                end else if (best_new == '0) begin
                    state_next = lupd_pkg::ST_SING;
                end else if (piv_new != i_reg) begin
                    state_next = lupd_pkg::ST_SWP_RD_A;
                end else if (i_reg == n_last) begin
                    state_next = lupd_pkg::ST_OUT_RD;
                end else begin
                    state_next = lupd_pkg::ST_E_RD_P;
                end
            end
            lupd_pkg::ST_SWP_RD_A: state_next = lupd_pkg::ST_SWP_RD_B;
            lupd_pkg::ST_SWP_RD_B: state_next = lupd_pkg::ST_SWP_WR_A;
            lupd_pkg::ST_SWP_WR_A: state_next = lupd_pkg::ST_SWP_WR_B;
            lupd_pkg::ST_SWP_WR_B: begin
                state_next = (k_reg == n_last) ? lupd_pkg::ST_PERM_A : lupd_pkg::ST_SWP_RD_A;
            end
            lupd_pkg::ST_PERM_A:   state_next = lupd_pkg::ST_PERM_B;
            lupd_pkg::ST_PERM_B:   state_next = lupd_pkg::ST_E_RD_P;
            lupd_pkg::ST_E_RD_P:   state_next = lupd_pkg::ST_E_RD_A;
            lupd_pkg::ST_E_RD_A:   state_next = lupd_pkg::ST_E_DIV_LD;
            lupd_pkg::ST_E_DIV_LD: state_next = lupd_pkg::ST_E_DIV;
            lupd_pkg::ST_E_DIV: begin
                if (cnt_reg == CNT_W'(1)) state_next = lupd_pkg::ST_E_DIV_WR;
            end
            lupd_pkg::ST_E_DIV_WR: state_next = lupd_pkg::ST_E_RD_U;
            lupd_pkg::ST_E_RD_U:   state_next = lupd_pkg::ST_E_RD_X;
            lupd_pkg::ST_E_RD_X:   state_next = lupd_pkg::ST_E_MUL;
            lupd_pkg::ST_E_MUL:    state_next = lupd_pkg::ST_E_WR;
            lupd_pkg::ST_E_WR: begin
                if (k_reg != n_last) begin
                    state_next = lupd_pkg::ST_E_RD_U;
                end else if (j_reg != n_last) begin
                    state_next = lupd_pkg::ST_E_RD_P;
                end else begin
                    state_next = lupd_pkg::ST_PIV_ISSUE;
                end
            end
            lupd_pkg::ST_OUT_RD: begin
                if (out_free) state_next = lupd_pkg::ST_OUT_LD;
            end
            lupd_pkg::ST_OUT_LD: begin
                if ((i_reg == n_last) && (k_reg == n_last)) begin
                    state_next = lupd_pkg::ST_LOAD;
                end else begin
                    state_next = lupd_pkg::ST_OUT_RD;
                end
            end
            lupd_pkg::ST_SING: begin
                if (out_free) state_next = lupd_pkg::ST_LOAD;
            end
            default: state_next = lupd_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        rd_addr = addr_of(i_reg, k_reg);
        wr_en   = 1'b0;
        wr_addr = addr_of(j_reg, k_reg);
        wr_data = diff_sat;
        unique case (state_reg)
            lupd_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                wr_en   = in_acc;
                wr_addr = addr_of(ld_row_reg, ld_col_reg);
                wr_data = s_element;
            end
            lupd_pkg::ST_PIV_ISSUE: rd_addr = addr_of(j_reg, i_reg);
            lupd_pkg::ST_SWP_RD_A:  rd_addr = addr_of(i_reg, k_reg);
            lupd_pkg::ST_SWP_RD_B:  rd_addr = addr_of(piv_reg, k_reg);
            lupd_pkg::ST_SWP_WR_A: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(i_reg, k_reg);
                wr_data = mem_q_reg;
            end
            lupd_pkg::ST_SWP_WR_B: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(piv_reg, k_reg);
                wr_data = tmp_reg;
            end
            lupd_pkg::ST_E_RD_P: rd_addr = addr_of(i_reg, i_reg);
            lupd_pkg::ST_E_RD_A: rd_addr = addr_of(j_reg, i_reg);
            lupd_pkg::ST_E_DIV_WR: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(j_reg, i_reg);
                wr_data = div_sat;
            end
            lupd_pkg::ST_E_RD_U: rd_addr = addr_of(i_reg, k_reg);
            lupd_pkg::ST_E_RD_X: rd_addr = addr_of(j_reg, k_reg);
            lupd_pkg::ST_E_WR: begin
                wr_en   = 1'b1;
                wr_addr = addr_of(j_reg, k_reg);
                wr_data = diff_sat;
            end
            lupd_pkg::ST_OUT_RD: rd_addr = addr_of(i_reg, k_reg);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lupd_pkg::ST_LOAD;
            size_reg      <= SW'(MAX_SIZE);
            ld_row_reg    <= '0;
            ld_col_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < MAX_SIZE; e++) ro_reg[e] <= IW'(e);
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready && state_reg != lupd_pkg::ST_SING) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                size_reg   <= pwdata[SW-1:0];
                ld_row_reg <= '0;
                ld_col_reg <= '0;
            end
            case (state_reg)
                lupd_pkg::ST_LOAD: begin
                    if (in_acc && !cfg_wr) begin
                        if (ld_col_reg == n_last) begin
                            ld_col_reg <= '0;
                            ld_row_reg <= ld_last ? '0 : ld_row_reg + IW'(1);
                        end else begin
                            ld_col_reg <= ld_col_reg + IW'(1);
                        end
                        if (ld_last) begin
                            for (int e = 0; e < MAX_SIZE; e++) ro_reg[e] <= IW'(e);
                            i_reg    <= '0;
                            j_reg    <= '0;
                            piv_reg  <= '0;
                            best_reg <= '0;
                        end
                    end
                end
                lupd_pkg::ST_PIV_CHECK: begin
                    best_reg <= best_new;
                    piv_reg  <= piv_new;
                    k_reg    <= '0;
                    if (j_reg != n_last) begin
                        j_reg <= j_reg + IW'(1);
                    end else begin
                        j_reg <= i_reg + IW'(1);
                    end
                end
                lupd_pkg::ST_SWP_RD_B: tmp_reg <= mem_q_reg;
                lupd_pkg::ST_SWP_WR_B: k_reg <= k_reg + IW'(1);
                lupd_pkg::ST_PERM_A:   ro_tmp_reg <= ro_reg[ro_idx];
                lupd_pkg::ST_PERM_B: begin
                    ro_reg[piv_reg[RO_W-1:0]] <= ro_reg[ro_idx];
                    ro_reg[ro_idx]            <= ro_tmp_reg;
                end
                lupd_pkg::ST_E_RD_A: piv_val_reg <= mem_q_reg;
                lupd_pkg::ST_E_DIV_LD: begin
                    rem_reg     <= '0;
                    quo_reg     <= {mag(mem_q_reg), FRACTION_BITS'(0)};
                    dvs_reg     <= mag(piv_val_reg);
                    div_neg_reg <= mem_q_reg[DW-1] ^ piv_val_reg[DW-1];
                    cnt_reg     <= CNT_W'(NUM_W);
                end
                lupd_pkg::ST_E_DIV: begin
                    if (!trial[DW]) begin
                        rem_reg <= trial[DW-1:0];
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[DW-2:0], quo_reg[NUM_W-1]};
                        quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                lupd_pkg::ST_E_DIV_WR: begin
                    m_reg <= div_sat;
                    k_reg <= i_reg + IW'(1);
                end
                lupd_pkg::ST_E_RD_X: u_reg <= mem_q_reg;
                lupd_pkg::ST_E_MUL: begin
                    x_reg        <= mem_q_reg;
                    prod_reg     <= mag(m_reg) * mag(u_reg);
                    prod_neg_reg <= m_reg[DW-1] ^ u_reg[DW-1];
                end
                lupd_pkg::ST_E_WR: begin
                    if (k_reg != n_last) begin
                        k_reg <= k_reg + IW'(1);
                    end else if (j_reg != n_last) begin
                        j_reg <= j_reg + IW'(1);
                    end else begin
                        i_reg    <= i_reg + IW'(1);
                        j_reg    <= i_reg + IW'(1);
                        piv_reg  <= i_reg + IW'(1);
                        best_reg <= '0;
                    end
                end
                lupd_pkg::ST_OUT_LD: begin
                    out_valid_reg <= 1'b1;
                    out_value_reg <= mem_q_reg;
                    out_row_reg   <= i_reg;
                    out_col_reg   <= k_reg;
                    out_perm_reg  <= ro_reg[ro_idx];
                    out_sing_reg  <= 1'b0;
                    out_final_reg <= (i_reg == n_last) && (k_reg == n_last);
                    if (k_reg == n_last) begin
                        k_reg <= '0;
                        i_reg <= i_reg + IW'(1);
                    end else begin
                        k_reg <= k_reg + IW'(1);
                    end
                end
                lupd_pkg::ST_SING: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= '0;
                        out_row_reg   <= '0;
                        out_col_reg   <= '0;
                        out_perm_reg  <= '0;
                        out_sing_reg  <= 1'b1;
                        out_final_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (state_reg == lupd_pkg::ST_PIV_CHECK && j_reg == n_last &&
                best_new != '0 && piv_new == i_reg && i_reg == n_last) begin
                i_reg <= '0;
            end
        end
    end

    assign prdata        = {{(32-SW){1'b0}}, size_reg};
    assign pready        = 1'b1;
    assign m_valid       = out_valid_reg;
    assign m_lu_value    = out_value_reg;
    assign m_row         = out_row_reg;
    assign m_column      = out_col_reg;
    assign m_perm_column = out_perm_reg;
    assign m_singular    = out_sing_reg;
    assign m_final_res   = out_final_reg;

    logic unused_paddr;
    assign unused_paddr = ^paddr;

endmodule

// ----- tb/lup_decomposition_test.sv -----
`timescale 1ns / 1ps

module lup_decomposition_test;

    localparam int DIM_MAX   = 8;
    localparam int FRAC_BITS = 16;
    localparam int SETTLE    = 60;
    localparam logic [1:0] REG_SIZE_IN_USE = 2'd0;

    typedef struct {
        logic signed [lupd_pkg::DATA_W-1:0] lu_value;
        logic [lupd_pkg::IDX_W-1:0]         row;
        logic [lupd_pkg::IDX_W-1:0]         column;
        logic [lupd_pkg::IDX_W-1:0]         perm_column;
        logic                               singular;
        logic                               final_res;
    } lu_result_t;

    typedef enum logic [1:0] {
        DO_SIZE,
        DO_ELEM,
        DO_ELEM_KNOWN
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic [31:0] value;
        logic        singular;
    } step_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [1:0]                         paddr;
    logic [31:0]                        pwdata;
    logic [31:0]                        prdata;
    logic                               pready;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [lupd_pkg::DATA_W-1:0] s_element;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [lupd_pkg::DATA_W-1:0] m_lu_value;
    logic [lupd_pkg::IDX_W-1:0]         m_row;
    logic [lupd_pkg::IDX_W-1:0]         m_column;
    logic [lupd_pkg::IDX_W-1:0]         m_perm_column;
    logic                               m_singular;
    logic                               m_final_res;

    lu_result_t  lu_expected[$];
    longint      lu_matrix[DIM_MAX*DIM_MAX];
    int unsigned load_count;
    int unsigned size_reg;
    int          mismatches;
    int          requests_sent;
    bit          steady;

    lup_decomposition #(
        .MAX_SIZE     (DIM_MAX),
        .FRACTION_BITS(FRAC_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_element    (s_element),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_lu_value   (m_lu_value),
        .m_row        (m_row),
        .m_column     (m_column),
        .m_perm_column(m_perm_column),
        .m_singular   (m_singular),
        .m_final_res  (m_final_res)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("lup_decomposition_test: errors");
        $finish;
    end

    function automatic int unsigned dim_of(int unsigned sz);
        if (sz < 1) return 1;
        if (sz > DIM_MAX) return DIM_MAX;
        return sz;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = (magn(a) * magn(b)) >>> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic longint fx_div(longint a, longint b);
        longint q;
        q = (magn(a) <<< FRAC_BITS) / magn(b);
        return sat32(((a < 0) != (b < 0)) ? -q : q);
    endfunction

    function automatic bit factor_in_place(int unsigned n, ref int perm[DIM_MAX]);
        longint best;
        longint mult;
        longint t;
        int     piv;
        int     tp;
        for (int i = 0; i < DIM_MAX; i++) perm[i] = i;
        for (int i = 0; i < n; i++) begin
            best = 0;
            piv  = i;
            for (int j = i; j < n; j++) begin
                if (magn(lu_matrix[j*DIM_MAX+i]) > best) begin
                    best = magn(lu_matrix[j*DIM_MAX+i]);
                    piv  = j;
                end
            end
            if (best == 0) return 1'b0;
            if (piv != i) begin
                tp = perm[i];
                perm[i] = perm[piv];
                perm[piv] = tp;
                for (int k = 0; k < n; k++) begin
                    t = lu_matrix[i*DIM_MAX+k];
                    lu_matrix[i*DIM_MAX+k] = lu_matrix[piv*DIM_MAX+k];
                    lu_matrix[piv*DIM_MAX+k] = t;
                end
            end
            for (int j = i + 1; j < n; j++) begin
                mult = fx_div(lu_matrix[j*DIM_MAX+i], lu_matrix[i*DIM_MAX+i]);
                lu_matrix[j*DIM_MAX+i] = mult;
                for (int k = i + 1; k < n; k++)
                    lu_matrix[j*DIM_MAX+k] = sat32(lu_matrix[j*DIM_MAX+k]
                        - fx_mul(mult, lu_matrix[i*DIM_MAX+k]));
            end
        end
        return 1'b1;
    endfunction

    function automatic void absorb_element(logic [31:0] raw);
        int unsigned n;
        int unsigned total;
        int          perm[DIM_MAX];
        lu_result_t  res;
        n     = dim_of(size_reg);
        total = n * n;
        if (load_count >= total) load_count = 0;
        lu_matrix[(load_count / n) * DIM_MAX + load_count % n] = longint'(signed'(raw));
        load_count++;
        if (load_count < total) return;
        load_count = 0;
        if (!factor_in_place(n, perm)) begin
            res = '{lu_value: '0, row: '0, column: '0, perm_column: '0,
                    singular: 1'b1, final_res: 1'b1};
            lu_expected.push_back(res);
            return;
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                res.lu_value    = lu_matrix[r*DIM_MAX+c][31:0];
                res.row         = r[lupd_pkg::IDX_W-1:0];
                res.column      = c[lupd_pkg::IDX_W-1:0];
                res.perm_column = perm[r][lupd_pkg::IDX_W-1:0];
                res.singular    = 1'b0;
                res.final_res   = (r * n + c + 1 == total);
                lu_expected.push_back(res);
            end
        end
    endfunction

    task automatic drain_results();
        while (lu_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_size(logic [31:0] v);
        s_valid <= 1'b0;
        drain_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_SIZE_IN_USE;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg   = v & 32'hF;
        load_count = 0;
    endtask

    task automatic send_element(logic [31:0] v);
        int gap;
        gap = (!steady && $urandom_range(99) < 25) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_element <= v;
        do @(posedge aclk); while (!s_ready);
        absorb_element(v);
        requests_sent++;
    endtask

    always @(posedge aclk) begin
        lu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (lu_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result lu=%h row=%0d col=%0d", m_lu_value, m_row,
                             m_column);
            end else begin
                want = lu_expected.pop_front();
                if (m_lu_value !== want.lu_value || m_row !== want.row
                        || m_column !== want.column || m_perm_column !== want.perm_column
                        || m_singular !== want.singular || m_final_res !== want.final_res) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp lu=%h r=%0d c=%0d p=%0d s=%b f=%b",
                                 want.lu_value, want.row, want.column, want.perm_column,
                                 want.singular, want.final_res,
                                 " | got lu=%h r=%0d c=%0d p=%0d s=%b f=%b",
                                 m_lu_value, m_row, m_column,
                                 m_perm_column, m_singular, m_final_res);
                end
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 25);
    end

    step_t directed_plan[] = '{
        '{DO_SIZE,       32'd1,          1'b0},
        '{DO_ELEM_KNOWN, 32'h0000_0000,  1'b1},
        '{DO_ELEM_KNOWN, 32'h7FFF_FFFF,  1'b0},
        '{DO_ELEM_KNOWN, 32'h8000_0000,  1'b0},
        '{DO_ELEM_KNOWN, 32'h0001_0000,  1'b0},
        '{DO_SIZE,       32'd0,          1'b0},
        '{DO_ELEM_KNOWN, 32'hFFFF_FFFB,  1'b0},
        '{DO_SIZE,       32'd2,          1'b0},
        '{DO_ELEM,       32'h0000_0000,  1'b0},
        '{DO_ELEM,       32'h0001_0000,  1'b0},
        '{DO_ELEM,       32'h0001_0000,  1'b0},
        '{DO_ELEM,       32'h0000_0000,  1'b0},
        '{DO_ELEM,       32'h0001_0000,  1'b0},
        '{DO_ELEM,       32'h0000_0000,  1'b0},
        '{DO_ELEM,       32'h0000_0000,  1'b0},
        '{DO_ELEM_KNOWN, 32'h0000_0000,  1'b1},
        '{DO_ELEM,       32'hFFFF_0000,  1'b0},
        '{DO_ELEM,       32'h7FFF_FFFF,  1'b0},
        '{DO_ELEM,       32'h0001_0000,  1'b0},
        '{DO_ELEM,       32'h7FFF_FFFF,  1'b0},
        '{DO_ELEM,       32'h0003_0000,  1'b0},
        '{DO_ELEM,       32'h0000_0001,  1'b0},
        '{DO_SIZE,       32'd2,          1'b0},
        '{DO_ELEM,       32'h8000_0000,  1'b0},
        '{DO_ELEM,       32'h0002_0000,  1'b0},
        '{DO_ELEM,       32'hFFFE_8000,  1'b0},
        '{DO_ELEM,       32'h7FFF_0000,  1'b0}
    };

    initial begin
        lu_result_t  known;
        int unsigned n;
        int          pick;
        int          mode;
        int          zero_col;
        int          cut;
        int          heavy_left;
        int          matrices;
        logic [31:0] v;
        aresetn    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_valid    = 1'b0;
        s_element  = '0;
        m_ready    = 1'b0;
        mismatches = 0;
        requests_sent = 0;
        steady     = 1'b0;
        heavy_left = 2;
        matrices   = 0;
        size_reg   = DIM_MAX;
        load_count = 0;
        foreach (lu_matrix[i]) lu_matrix[i] = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == DO_SIZE) begin
                write_size(directed_plan[i].value);
            end else begin
                send_element(directed_plan[i].value);
                if (directed_plan[i].kind == DO_ELEM_KNOWN) begin
                    void'(lu_expected.pop_back());
                    known = '{lu_value: directed_plan[i].singular ? '0 : directed_plan[i].value,
                              row: '0, column: '0, perm_column: '0,
                              singular: directed_plan[i].singular, final_res: 1'b1};
                    lu_expected.push_back(known);
                end
            end
        end

        while (requests_sent < 255) begin
            matrices++;
            steady = (matrices >= 12 && matrices < 22);
            if (matrices == 30) begin
                s_valid <= 1'b0;
                drain_results();
            end
            pick = $urandom_range(99);
            if (pick < 6 && heavy_left > 0) begin
                heavy_left--;
                write_size($urandom_range(1) ? 32'd8 : 32'd15);
            end else if (pick < 10) begin
                write_size(32'd0);
            end else if (pick < 40) begin
                write_size($urandom_range(1, 5));
            end
            n        = dim_of(size_reg);
            mode     = $urandom_range(3);
            zero_col = $urandom_range(n - 1);
            cut      = ($urandom_range(99) < 8 && n > 1) ? $urandom_range(1, n * n - 1) : n * n;
            for (int k = 0; k < cut; k++) begin
                case (mode)
                    0: v = $urandom;
                    1: v = ($urandom_range(6) - 3) << FRAC_BITS;
                    2: v = (k % n == zero_col) ? 32'd0 : ($urandom_range(8) - 4) << 15;
                    default: begin
                        pick = $urandom_range(2);
                        v = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 : $urandom;
                    end
                endcase
                send_element(v);
            end
            if (cut != n * n) write_size(size_reg);
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (lu_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && lu_expected.size() == 0)
            $display("lup_decomposition_test: clean");
        else
            $display("lup_decomposition_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lupd_pkg.sv
sv/lup_decomposition.sv
tb/lup_decomposition_test.sv
